[src/sha1_hash_engine_macros.svh]
// Assertion macros shared by the SHA-1 engine modules.
// Expects clk and rst_n in the scope of each use.
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// Same-cycle implication.
`define SHA1_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sha1_pkg.sv]
// Shared types and constants of the SHA-1 engine.
// No dependencies; used by the controller, datapath and top level.
package sha1_pkg;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned BLOCK_BITS   = 512;

  localparam logic [31:0] SHA1_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  localparam logic [6:0] ROUND_B1   = 7'd20;
  localparam logic [6:0] ROUND_B2   = 7'd40;
  localparam logic [6:0] ROUND_B3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [5:0] BYTE_LAST  = 6'd63;
  localparam logic [5:0] BYTE_LEN   = 6'd56;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPRESS,
    S_FINAL,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    logic  put;
    bsel_t bsel;
    logic  round_start;
    logic  round_step;
    logic  chain_add;
    logic  emit_step;
    logic  chain_init;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic at_len;
    logic round_last;
    logic emit_last;
  } ctl_sts_t;

endpackage

[src/sha1_if.sv]
// Request and response channel interfaces of the SHA-1 engine.
// Depends on nothing; widths follow the request and digest fields.
interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface sha1_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

[src/sha1_ctrl.sv]
// Controller of the SHA-1 engine: request acceptance, padding, compression
// sequencing and digest emission. Depends on sha1_pkg and the macro header.
`include "sha1_hash_engine_macros.svh"

module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  ctl_state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_FINISH) begin
            state_nxt = S_PAD_MARK;
          end else if (sts.full) begin
            state_nxt = S_COMPRESS;
            ret_nxt   = S_IDLE;
          end
        end
      end
      S_COMPRESS: begin
        if (sts.round_last) state_nxt = S_FINAL;
      end
      S_FINAL: state_nxt = ret_r;
      S_PAD_MARK: begin
        if (sts.full) begin
          state_nxt = S_COMPRESS;
          ret_nxt   = S_PAD_ZERO;
        end else begin
          state_nxt = S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        if (sts.at_len) begin
          state_nxt = S_PAD_LEN;
        end else if (sts.full) begin
          state_nxt = S_COMPRESS;
          ret_nxt   = S_PAD_ZERO;
        end
      end
      S_PAD_LEN: begin
        if (sts.full) begin
          state_nxt = S_COMPRESS;
          ret_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready && sts.emit_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.bsel  = BSEL_DATA;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_cmd == CMD_ABSORB) begin
          cmd.put         = 1'b1;
          cmd.round_start = sts.full;
        end
      end
      S_COMPRESS: cmd.round_step = 1'b1;
      S_FINAL:    cmd.chain_add  = 1'b1;
      S_PAD_MARK: begin
        cmd.put         = 1'b1;
        cmd.bsel        = BSEL_MARK;
        cmd.round_start = sts.full;
      end
      S_PAD_ZERO: begin
        if (!sts.at_len) begin
          cmd.put         = 1'b1;
          cmd.bsel        = BSEL_ZERO;
          cmd.round_start = sts.full;
        end
      end
      S_PAD_LEN: begin
        cmd.put         = 1'b1;
        cmd.bsel        = BSEL_LEN;
        cmd.round_start = sts.full;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_step  = 1'b1;
          cmd.chain_init = sts.emit_last;
        end
      end
      default: ;
    endcase
  end

  `SHA1_ASSERT_NEXT(a_round_to_final, state_r == S_COMPRESS && sts.round_last, state_r == S_FINAL, "last round must finalize")
  `SHA1_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && sts.emit_last, state_r == S_IDLE, "digest end must return to idle")
  `SHA1_ASSERT_SAME(a_no_overlap, in_ready, !out_valid, "request and response must not overlap")

endmodule

[src/sha1_dp.sv]
// Datapath of the SHA-1 engine: block shift line, message schedule, round
// registers, chaining words and bit length. Depends on sha1_pkg and macros.
`include "sha1_hash_engine_macros.svh"

module sha1_dp
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  output ctl_sts_t    sts,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);

  logic [BLOCK_BITS-1:0] buf_r;
  logic [5:0]            byte_idx_r;
  logic [63:0]           len_r;
  logic [31:0]           chain_r [DIGEST_WORDS];
  logic [31:0]           a_r, b_r, c_r, d_r, e_r;
  logic [6:0]            round_r;
  logic [2:0]            word_idx_r;

  logic [63:0] len_shift;
  logic [7:0]  put_byte;
  logic [31:0] w0, w2, w8, w13, w_new;
  logic [31:0] f, k, t;

  function automatic logic [31:0] w_tmp_rot(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  assign len_shift = len_r >> {~byte_idx_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.bsel)
      BSEL_DATA: put_byte = data_byte;
      BSEL_MARK: put_byte = PAD_MARKER;
      BSEL_ZERO: put_byte = '0;
      BSEL_LEN:  put_byte = len_shift[7:0];
      default:   put_byte = '0;
    endcase
  end

  assign w0    = buf_r[511:480];
  assign w2    = buf_r[447:416];
  assign w8    = buf_r[255:224];
  assign w13   = buf_r[95:64];
  assign w_new = {w_tmp_rot(w13 ^ w8 ^ w2 ^ w0)};

  always_comb begin
    if (round_r < ROUND_B1) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K_R0;
    end else if (round_r < ROUND_B2) begin
      f = b_r ^ c_r ^ d_r;
      k = K_R1;
    end else if (round_r < ROUND_B3) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K_R2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_R3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w0;
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      buf_r <= {buf_r[BLOCK_BITS-9:0], put_byte};
    end else if (cmd.round_step) begin
      buf_r <= {buf_r[BLOCK_BITS-33:0], w_new};
    end
    if (cmd.round_start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_step) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
      len_r      <= '0;
      round_r    <= '0;
      word_idx_r <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) chain_r[i] <= SHA1_INIT[i];
    end else begin
      if (cmd.chain_init) begin
        byte_idx_r <= '0;
        len_r      <= '0;
        for (int i = 0; i < DIGEST_WORDS; i++) chain_r[i] <= SHA1_INIT[i];
      end else begin
        if (cmd.put) byte_idx_r <= byte_idx_r + 6'd1;
        if (cmd.put && cmd.bsel == BSEL_DATA) len_r <= len_r + BITS_PER_BYTE;
        if (cmd.chain_add) begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
        end
      end
      if (cmd.round_start) begin
        round_r <= '0;
      end else if (cmd.round_step) begin
        round_r <= round_r + 7'd1;
      end
      if (cmd.emit_step) word_idx_r <= sts.emit_last ? 3'd0 : word_idx_r + 3'd1;
    end
  end

  assign sts.full       = byte_idx_r == BYTE_LAST;
  assign sts.at_len     = byte_idx_r == BYTE_LEN;
  assign sts.round_last = round_r == ROUND_LAST;
  assign sts.emit_last  = word_idx_r == WORD_LAST;

  assign digest_word = chain_r[word_idx_r];
  assign word_index  = word_idx_r;
  assign last        = sts.emit_last;

  `SHA1_ASSERT_NEXT(a_wrap_block, cmd.put && sts.full && !cmd.chain_init, byte_idx_r == 6'd0, "full block must wrap byte index")
  `SHA1_ASSERT_NEXT(a_round_clear, cmd.round_start, round_r == 7'd0, "round counter must restart")
  `SHA1_ASSERT_NEXT(a_init_clear, cmd.chain_init, len_r == 64'd0 && byte_idx_r == 6'd0, "finish must clear length")

endmodule

[src/sha1_hash_engine.sv]
// SHA-1 engine top level; depends on sha1_pkg, sha1_if, ctrl, dp. A data byte is
// taken while idle; the 64th byte of a block starts compression: 80 rounds, one
// per cycle, then the chaining add. On finish, pad bytes go in at one per cycle to
// the end of this block or the next, each padded block is compressed, then 5 words
// go out at one per cycle while out_ready is high; no input is taken outside idle.
// Synchronous active-low reset loads the initial hash and clears length and index.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sha1_req_if.sink  in_req,
  sha1_rsp_if.source out_rsp
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_cmd    (in_req.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_req.data_byte),
    .sts         (sts),
    .digest_word (out_rsp.digest_word),
    .word_index  (out_rsp.word_index),
    .last        (out_rsp.last)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;

endmodule
